// ===== sv/lps_pkg.sv =====
// Shared types, codes and constants for the LED publish sequencer.
package lps_pkg;

  // One-hot phase codes; phase_code() maps them to the dense output numbering.
  typedef enum logic [19:0] {
    PH_IDLE        = 20'h00001,
    PH_PRE_ON1     = 20'h00002,
    PH_PRE_OFF1    = 20'h00004,
    PH_PRE_ON2     = 20'h00008,
    PH_PRE_OFF2    = 20'h00010,
    PH_TRY         = 20'h00020,
    PH_RETRY_WAIT  = 20'h00040,
    PH_POST_WAIT   = 20'h00080,
    PH_POST_ON1    = 20'h00100,
    PH_POST_OFF1   = 20'h00200,
    PH_POST_ON2    = 20'h00400,
    PH_POST_OFF2   = 20'h00800,
    PH_FAIL_ON1    = 20'h01000,
    PH_FAIL_OFF1   = 20'h02000,
    PH_FAIL_ON2    = 20'h04000,
    PH_FAIL_OFF2   = 20'h08000,
    PH_FAIL_ON3    = 20'h10000,
    PH_FAIL_OFF3   = 20'h20000,
    PH_REFRESH_ON  = 20'h40000,
    PH_REFRESH_OFF = 20'h80000
  } phase_e;

  typedef enum logic [2:0] {
    MODE_TICK              = 3'd0,
    MODE_START             = 3'd1,
    MODE_REFRESH_BEGIN     = 3'd2,
    MODE_REFRESH_END       = 3'd3,
    MODE_REFRESH_END_AFTER = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    REG_STEP_MS          = 3'd0,
    REG_FAIL_FLASH_MS    = 3'd1,
    REG_POST_WAIT_MS     = 3'd2,
    REG_RETRY_DELAY_MS   = 3'd3,
    REG_MAX_ATTEMPTS     = 3'd4,
    REG_REFRESH_PULSE_MS = 3'd5
  } reg_idx_e;

  localparam logic [15:0] StepMsRst         = 16'd150;
  localparam logic [15:0] FailFlashMsRst    = 16'd100;
  localparam logic [15:0] PostWaitMsRst     = 16'd500;
  localparam logic [15:0] RetryDelayMsRst   = 16'd1000;
  localparam logic [7:0]  MaxAttemptsRst    = 8'd3;
  localparam logic [15:0] RefreshPulseMsRst = 16'd500;

  localparam logic [15:0] TimeMax  = 16'hFFFF;
  localparam logic [7:0]  CountMax = 8'hFF;

  typedef struct packed {
    logic [15:0] step_ms;
    logic [15:0] fail_flash_ms;
    logic [15:0] post_wait_ms;
    logic [15:0] retry_delay_ms;
    logic [7:0]  max_attempts;
    logic [15:0] refresh_pulse_ms;
  } cfg_t;

  typedef struct packed {
    phase_e      phase;
    logic        led;
    logic [15:0] phase_elapsed;
    logic [15:0] phase_length;
    logic [7:0]  fail_count;
    logic        refresh_wanted;
    logic        deadline_armed;
    logic [15:0] deadline_elapsed;
    logic [15:0] deadline_length;
  } state_t;

  typedef struct packed {
    logic       led_on;
    logic [4:0] phase;
    logic       tx_busy;
    logic       active;
    logic       publish_attempt;
    logic       enter_hold;
  } result_t;

  function automatic logic [4:0] phase_code(phase_e ph);
    logic [4:0] code;
    case (ph)
      PH_IDLE:        code = 5'd0;
      PH_PRE_ON1:     code = 5'd1;
      PH_PRE_OFF1:    code = 5'd2;
      PH_PRE_ON2:     code = 5'd3;
      PH_PRE_OFF2:    code = 5'd4;
      PH_TRY:         code = 5'd5;
      PH_RETRY_WAIT:  code = 5'd6;
      PH_POST_WAIT:   code = 5'd7;
      PH_POST_ON1:    code = 5'd8;
      PH_POST_OFF1:   code = 5'd9;
      PH_POST_ON2:    code = 5'd10;
      PH_POST_OFF2:   code = 5'd11;
      PH_FAIL_ON1:    code = 5'd12;
      PH_FAIL_OFF1:   code = 5'd13;
      PH_FAIL_ON2:    code = 5'd14;
      PH_FAIL_OFF2:   code = 5'd15;
      PH_FAIL_ON3:    code = 5'd16;
      PH_FAIL_OFF3:   code = 5'd17;
      PH_REFRESH_ON:  code = 5'd18;
      PH_REFRESH_OFF: code = 5'd19;
      default:        code = 5'd0;
    endcase
    return code;
  endfunction

endpackage

// ===== sv/lps_cfg.sv =====
// Configuration register file of the LED publish sequencer.
module lps_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  output lps_pkg::cfg_t       cfg_o
);

  lps_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_ms          <= lps_pkg::StepMsRst;
      cfg_q.fail_flash_ms    <= lps_pkg::FailFlashMsRst;
      cfg_q.post_wait_ms     <= lps_pkg::PostWaitMsRst;
      cfg_q.retry_delay_ms   <= lps_pkg::RetryDelayMsRst;
      cfg_q.max_attempts     <= lps_pkg::MaxAttemptsRst;
      cfg_q.refresh_pulse_ms <= lps_pkg::RefreshPulseMsRst;
    end else if (cfg_valid_i) begin
      case (lps_pkg::reg_idx_e'(cfg_index_i))
        lps_pkg::REG_STEP_MS:          cfg_q.step_ms          <= cfg_data_i;
        lps_pkg::REG_FAIL_FLASH_MS:    cfg_q.fail_flash_ms    <= cfg_data_i;
        lps_pkg::REG_POST_WAIT_MS:     cfg_q.post_wait_ms     <= cfg_data_i;
        lps_pkg::REG_RETRY_DELAY_MS:   cfg_q.retry_delay_ms   <= cfg_data_i;
        lps_pkg::REG_MAX_ATTEMPTS:     cfg_q.max_attempts     <= cfg_data_i[7:0];
        lps_pkg::REG_REFRESH_PULSE_MS: cfg_q.refresh_pulse_ms <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/lps_step.sv =====
// Next-state and result logic for one request of the LED publish sequencer.
module lps_step (
  input  lps_pkg::cfg_t    cfg_i,
  input  lps_pkg::state_t  st_i,
  input  logic [2:0]       mode_i,
  input  logic             publish_ok_i,
  input  logic [15:0]      deadline_ms_i,
  output lps_pkg::state_t  st_o,
  output lps_pkg::result_t res_o
);

  lps_pkg::state_t nxt;
  logic            tried;
  logic            hold;
  logic [7:0]      fail_inc;

  assign fail_inc = (st_i.fail_count != lps_pkg::CountMax) ?
                    st_i.fail_count + 8'd1 : st_i.fail_count;

  always_comb begin
    nxt   = st_i;
    tried = 1'b0;
    hold  = 1'b0;
    case (lps_pkg::mode_e'(mode_i))
      lps_pkg::MODE_TICK: begin
        if (nxt.phase_elapsed != lps_pkg::TimeMax) begin
          nxt.phase_elapsed = nxt.phase_elapsed + 16'd1;
        end
        if (nxt.deadline_elapsed != lps_pkg::TimeMax) begin
          nxt.deadline_elapsed = nxt.deadline_elapsed + 16'd1;
        end
        // drop the refresh request once its deadline runs out
        if (nxt.deadline_armed && (nxt.deadline_elapsed >= nxt.deadline_length)) begin
          nxt.refresh_wanted = 1'b0;
          nxt.deadline_armed = 1'b0;
        end
        if (st_i.phase == lps_pkg::PH_IDLE) begin
          if (nxt.refresh_wanted) begin
            nxt.led           = 1'b1;
            nxt.phase         = lps_pkg::PH_REFRESH_ON;
            nxt.phase_elapsed = '0;
            nxt.phase_length  = cfg_i.refresh_pulse_ms;
          end
        end else if (nxt.phase_elapsed >= nxt.phase_length) begin
          nxt.phase_elapsed = '0;
          case (st_i.phase)
            lps_pkg::PH_PRE_ON1: begin
              nxt.led = 1'b0; nxt.phase = lps_pkg::PH_PRE_OFF1;
              nxt.phase_length = cfg_i.step_ms;
            end
            lps_pkg::PH_PRE_OFF1: begin
              nxt.led = 1'b1; nxt.phase = lps_pkg::PH_PRE_ON2;
              nxt.phase_length = cfg_i.step_ms;
            end
            lps_pkg::PH_PRE_ON2: begin
              nxt.led = 1'b0; nxt.phase = lps_pkg::PH_PRE_OFF2;
              nxt.phase_length = cfg_i.step_ms;
            end
            lps_pkg::PH_PRE_OFF2: begin
              nxt.fail_count   = '0;
              nxt.phase        = lps_pkg::PH_TRY;
              nxt.phase_length = '0;
            end
            lps_pkg::PH_TRY: begin
              tried = 1'b1;
              if (publish_ok_i) begin
                nxt.phase        = lps_pkg::PH_POST_WAIT;
                nxt.phase_length = cfg_i.post_wait_ms;
              end else begin
                nxt.fail_count = fail_inc;
                if (fail_inc >= cfg_i.max_attempts) begin
                  nxt.led          = 1'b1;
                  nxt.phase        = lps_pkg::PH_FAIL_ON1;
                  nxt.phase_length = cfg_i.fail_flash_ms;
                end else begin
                  nxt.phase        = lps_pkg::PH_RETRY_WAIT;
                  nxt.phase_length = cfg_i.retry_delay_ms;
                end
              end
            end
            lps_pkg::PH_RETRY_WAIT: begin
              nxt.phase        = lps_pkg::PH_TRY;
              nxt.phase_length = '0;
            end
            lps_pkg::PH_POST_WAIT: begin
              nxt.led = 1'b1; nxt.phase = lps_pkg::PH_POST_ON1;
              nxt.phase_length = cfg_i.step_ms;
            end
            lps_pkg::PH_POST_ON1: begin
              nxt.led = 1'b0; nxt.phase = lps_pkg::PH_POST_OFF1;
              nxt.phase_length = cfg_i.step_ms;
            end
            lps_pkg::PH_POST_OFF1: begin
              nxt.led = 1'b1; nxt.phase = lps_pkg::PH_POST_ON2;
              nxt.phase_length = cfg_i.step_ms;
            end
            lps_pkg::PH_POST_ON2: begin
              nxt.led = 1'b0; nxt.phase = lps_pkg::PH_POST_OFF2;
              nxt.phase_length = cfg_i.step_ms;
            end
            lps_pkg::PH_FAIL_ON1: begin
              nxt.led = 1'b0; nxt.phase = lps_pkg::PH_FAIL_OFF1;
              nxt.phase_length = cfg_i.fail_flash_ms;
            end
            lps_pkg::PH_FAIL_OFF1: begin
              nxt.led = 1'b1; nxt.phase = lps_pkg::PH_FAIL_ON2;
              nxt.phase_length = cfg_i.fail_flash_ms;
            end
            lps_pkg::PH_FAIL_ON2: begin
              nxt.led = 1'b0; nxt.phase = lps_pkg::PH_FAIL_OFF2;
              nxt.phase_length = cfg_i.fail_flash_ms;
            end
            lps_pkg::PH_FAIL_OFF2: begin
              nxt.led = 1'b1; nxt.phase = lps_pkg::PH_FAIL_ON3;
              nxt.phase_length = cfg_i.fail_flash_ms;
            end
            lps_pkg::PH_FAIL_ON3: begin
              nxt.led = 1'b0; nxt.phase = lps_pkg::PH_FAIL_OFF3;
              nxt.phase_length = cfg_i.fail_flash_ms;
            end
            lps_pkg::PH_POST_OFF2, lps_pkg::PH_FAIL_OFF3: begin
              if (nxt.refresh_wanted) begin
                nxt.led          = 1'b1;
                nxt.phase        = lps_pkg::PH_REFRESH_ON;
                nxt.phase_length = cfg_i.refresh_pulse_ms;
              end else begin
                nxt.phase_elapsed = st_i.phase_elapsed == lps_pkg::TimeMax ?
                                    lps_pkg::TimeMax : st_i.phase_elapsed + 16'd1;
                nxt.phase = lps_pkg::PH_IDLE;
                hold      = 1'b1;
              end
            end
            lps_pkg::PH_REFRESH_ON, lps_pkg::PH_REFRESH_OFF: begin
              if (!nxt.refresh_wanted) begin
                // going idle keeps the counted time, as no new phase starts
                nxt.phase_elapsed = st_i.phase_elapsed == lps_pkg::TimeMax ?
                                    lps_pkg::TimeMax : st_i.phase_elapsed + 16'd1;
                nxt.phase = lps_pkg::PH_IDLE;
                hold      = 1'b1;
              end else begin
                nxt.led   = (st_i.phase == lps_pkg::PH_REFRESH_OFF);
                nxt.phase = (st_i.phase == lps_pkg::PH_REFRESH_ON) ?
                            lps_pkg::PH_REFRESH_OFF : lps_pkg::PH_REFRESH_ON;
                nxt.phase_length = cfg_i.refresh_pulse_ms;
              end
            end
            default: begin
              // hold the counted time in a phase without a successor
              nxt.phase_elapsed = st_i.phase_elapsed == lps_pkg::TimeMax ?
                                  lps_pkg::TimeMax : st_i.phase_elapsed + 16'd1;
            end
          endcase
        end
      end
      lps_pkg::MODE_START: begin
        nxt.led           = 1'b1;
        nxt.phase         = lps_pkg::PH_PRE_ON1;
        nxt.phase_elapsed = '0;
        nxt.phase_length  = cfg_i.step_ms;
      end
      lps_pkg::MODE_REFRESH_BEGIN: begin
        nxt.deadline_armed = 1'b0;
        nxt.refresh_wanted = 1'b1;
        if (st_i.phase == lps_pkg::PH_IDLE) begin
          nxt.led           = 1'b1;
          nxt.phase         = lps_pkg::PH_REFRESH_ON;
          nxt.phase_elapsed = '0;
          nxt.phase_length  = cfg_i.refresh_pulse_ms;
        end
      end
      lps_pkg::MODE_REFRESH_END: begin
        nxt.refresh_wanted = 1'b0;
        nxt.deadline_armed = 1'b0;
      end
      lps_pkg::MODE_REFRESH_END_AFTER: begin
        nxt.deadline_elapsed = '0;
        nxt.deadline_length  = deadline_ms_i;
        nxt.deadline_armed   = 1'b1;
      end
      default: ;
    endcase
  end

  assign st_o = nxt;

  always_comb begin
    res_o.led_on          = nxt.led;
    res_o.phase           = lps_pkg::phase_code(nxt.phase);
    res_o.active          = (nxt.phase != lps_pkg::PH_IDLE);
    res_o.tx_busy         = (nxt.phase != lps_pkg::PH_IDLE) &&
                            (nxt.phase != lps_pkg::PH_REFRESH_ON) &&
                            (nxt.phase != lps_pkg::PH_REFRESH_OFF);
    res_o.publish_attempt = tried;
    res_o.enter_hold      = hold;
  end

endmodule

// ===== sv/led_publish_sequencer_core.sv =====
// Top level of the LED publish sequencer: request and result registers around the step logic.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request: mode_i selects a 1 ms
//   tick, start send, refresh begin, refresh end or refresh end after deadline_ms_i;
//   publish_ok_i is sampled on a tick that ends a publish try.
//   Output channel (out_valid_o / out_stall_i) returns exactly one result per request:
//   LED level, phase code, busy flags, publish-try strobe and the return-to-idle pulse.
//   Configuration writes (cfg_valid_i, cfg_index_i, cfg_data_i) are always ready and
//   take effect on the next request; indexes 6 and 7 are ignored.
// Timing:
//   A request taken into the request register is evaluated into the result register
//   once the result register is free, and its result is shown from there. One request
//   per cycle is sustained while the output is not stalled; the step is a single pass of
//   compare-and-select logic against the state register.
// Reset:
//   Phase idle, LED off, timers and counters cleared, configuration at defaults.
// Stall:
//   A held result stalls the request register; the input channel stalls only when
//   both registers are full, so results are never dropped or repeated.
module led_publish_sequencer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  mode_i,
  input  logic        publish_ok_i,
  input  logic [15:0] deadline_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        led_on_o,
  output logic [4:0]  phase_o,
  output logic        tx_busy_o,
  output logic        active_o,
  output logic        publish_attempt_o,
  output logic        enter_hold_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  lps_pkg::cfg_t    cfg;
  lps_pkg::state_t  st_q, st_d;
  lps_pkg::result_t res_d, res_q;

  logic        req_valid_q;
  logic [2:0]  mode_q;
  logic        ok_q;
  logic [15:0] dl_q;
  logic        out_valid_q;
  logic        out_free;
  logic        advance;
  logic        take;

  assign cfg_ready_o = 1'b1;

  lps_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lps_step u_step (
    .cfg_i         (cfg),
    .st_i          (st_q),
    .mode_i        (mode_q),
    .publish_ok_i  (ok_q),
    .deadline_ms_i (dl_q),
    .st_o          (st_d),
    .res_o         (res_d)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = req_valid_q && out_free;
  assign in_stall_o = req_valid_q && !out_free;
  assign take       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        req_valid_q <= 1'b1;
      end else if (advance) begin
        req_valid_q <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= req_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase            <= lps_pkg::PH_IDLE;
      st_q.led              <= 1'b0;
      st_q.phase_elapsed    <= '0;
      st_q.phase_length     <= '0;
      st_q.fail_count       <= '0;
      st_q.refresh_wanted   <= 1'b0;
      st_q.deadline_armed   <= 1'b0;
      st_q.deadline_elapsed <= '0;
      st_q.deadline_length  <= '0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // payload registers: load on take / advance only
  always_ff @(posedge clk_i) begin
    if (take) begin
      mode_q <= mode_i;
      ok_q   <= publish_ok_i;
      dl_q   <= deadline_ms_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign led_on_o          = res_q.led_on;
  assign phase_o           = res_q.phase;
  assign tx_busy_o         = res_q.tx_busy;
  assign active_o          = res_q.active;
  assign publish_attempt_o = res_q.publish_attempt;
  assign enter_hold_o      = res_q.enter_hold;

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the LED publish sequencer core.
module tb;
  import lps_pkg::*;

  // Dense phase numbering as it appears on phase_o.
  typedef enum logic [4:0] {
    S_IDLE, S_PRE_ON1, S_PRE_OFF1, S_PRE_ON2, S_PRE_OFF2, S_TRY, S_RETRY_WAIT,
    S_POST_WAIT, S_POST_ON1, S_POST_OFF1, S_POST_ON2, S_POST_OFF2,
    S_FAIL_ON1, S_FAIL_OFF1, S_FAIL_ON2, S_FAIL_OFF2, S_FAIL_ON3, S_FAIL_OFF3,
    S_REF_ON, S_REF_OFF
  } seq_ph_e;

  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam logic [2:0] REG_SPARE_LO  = 3'd6;
  localparam logic [2:0] REG_SPARE_HI  = 3'd7;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int RANDOM_ROUNDS   = 13;
  localparam int ROUND_REQUESTS  = 50;
  localparam int REPORT_MAX      = 10;
  localparam int PLAN_ROWS       = 29;

  localparam result_t RES_IDLE = '0;
  localparam result_t RES_PRE1 = '{led_on: 1'b1, phase: S_PRE_ON1, tx_busy: 1'b1,
                                   active: 1'b1, publish_attempt: 1'b0, enter_hold: 1'b0};

  typedef struct packed {
    logic        cfg;    // register write instead of a request
    logic [2:0]  idx;
    logic [15:0] data;
    logic [2:0]  mode;
    logic        ok;
    logic [15:0] dl;
    logic        known;  // expected result typed in below
    result_t     want;
  } plan_row_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  mode_i = MODE_TICK;
  logic        publish_ok_i = 1'b0;
  logic [15:0] deadline_ms_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        led_on_o;
  logic [4:0]  phase_o;
  logic        tx_busy_o;
  logic        active_o;
  logic        publish_attempt_o;
  logic        enter_hold_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = REG_STEP_MS;
  logic [15:0] cfg_data_i = '0;

  led_publish_sequencer_core dut (.*);

  // Sequencer shadow state and its configuration.
  seq_ph_e     lamp_ph = S_IDLE;
  logic        lamp_led = 1'b0;
  logic [15:0] lamp_elapsed = '0;
  logic [15:0] lamp_length = '0;
  logic [7:0]  lamp_fails = '0;
  logic        lamp_want = 1'b0;
  logic        lamp_armed = 1'b0;
  logic [15:0] lamp_dl_elapsed = '0;
  logic [15:0] lamp_dl_length = '0;
  cfg_t        lamp_cfg = '{StepMsRst, FailFlashMsRst, PostWaitMsRst, RetryDelayMsRst,
                            MaxAttemptsRst, RefreshPulseMsRst};

  result_t lamp_due[$];
  int      faults = 0;
  int      results_seen = 0;
  int      quiet_cycles = 0;
  int      tx_calm = 0;
  int      rx_calm = 0;

  plan_row_t plan [0:PLAN_ROWS-1] = '{
    '{1'b0, REG_STEP_MS, 16'd0, MODE_TICK, 1'b0, 16'd0, 1'b1, RES_IDLE},
    '{1'b0, REG_STEP_MS, 16'd0, MODE_SPARE_LO, 1'b1, 16'hFFFF, 1'b1, RES_IDLE},
    '{1'b0, REG_STEP_MS, 16'd0, MODE_START, 1'b0, 16'd0, 1'b1, RES_PRE1},
    '{1'b0, REG_STEP_MS, 16'd0, MODE_SPARE_HI, 1'b1, 16'hFFFF, 1'b1, RES_PRE1},
    '{1'b0, REG_STEP_MS, 16'd0, MODE_REFRESH_BEGIN, 1'b0, 16'd0, 1'b1, RES_PRE1},
    '{1'b0, REG_STEP_MS, 16'd0, MODE_REFRESH_END_AFTER, 1'b0, 16'd0, 1'b1, RES_PRE1},
    '{1'b0, REG_STEP_MS, 16'd0, MODE_TICK, 1'b1, 16'd0, 1'b0, RES_IDLE},
    '{1'b1, REG_STEP_MS, 16'd0, MODE_TICK, 1'b0, 16'd0, 1'b0, RES_IDLE},
    '{1'b1, REG_FAIL_FLASH_MS, 16'd0, MODE_TICK, 1'b0, 16'd0, 1'b0, RES_IDLE},
    '{1'b1, REG_POST_WAIT_MS, 16'd0, MODE_TICK, 1'b0, 16'd0, 1'b0, RES_IDLE},
    '{1'b1, REG_RETRY_DELAY_MS, 16'd0, MODE_TICK, 1'b0, 16'd0, 1'b0, RES_IDLE},
    '{1'b1, REG_MAX_ATTEMPTS, 16'd0, MODE_TICK, 1'b0, 16'd0, 1'b0, RES_IDLE},
    '{1'b1, REG_REFRESH_PULSE_MS, 16'd0, MODE_TICK, 1'b0, 16'd0, 1'b0, RES_IDLE},
    // restart while running, then walk to the first try with zero durations
    '{1'b0, REG_STEP_MS, 16'd0, MODE_START, 1'b1, 16'd0, 1'b0, RES_IDLE},
    '{1'b0, REG_STEP_MS, 16'd0, MODE_TICK, 1'b1, 16'd0, 1'b0, RES_IDLE},
    '{1'b0, REG_STEP_MS, 16'd0, MODE_TICK, 1'b1, 16'd0, 1'b0, RES_IDLE},
    '{1'b0, REG_STEP_MS, 16'd0, MODE_TICK, 1'b1, 16'd0, 1'b0, RES_IDLE},
    '{1'b0, REG_STEP_MS, 16'd0, MODE_TICK, 1'b1, 16'd0, 1'b0, RES_IDLE},
    // no attempts allowed: the first failure flashes at once
    '{1'b0, REG_STEP_MS, 16'd0, MODE_TICK, 1'b0, 16'd0, 1'b0, RES_IDLE},
    '{1'b0, REG_STEP_MS, 16'd0, MODE_REFRESH_BEGIN, 1'b0, 16'd0, 1'b0, RES_IDLE},
    '{1'b0, REG_STEP_MS, 16'd0, MODE_TICK, 1'b0, 16'd0, 1'b0, RES_IDLE},
    '{1'b0, REG_STEP_MS, 16'd0, MODE_TICK, 1'b0, 16'd0, 1'b0, RES_IDLE},
    '{1'b0, REG_STEP_MS, 16'd0, MODE_TICK, 1'b0, 16'd0, 1'b0, RES_IDLE},
    '{1'b0, REG_STEP_MS, 16'd0, MODE_TICK, 1'b0, 16'd0, 1'b0, RES_IDLE},
    '{1'b0, REG_STEP_MS, 16'd0, MODE_TICK, 1'b0, 16'd0, 1'b0, RES_IDLE},
    '{1'b0, REG_STEP_MS, 16'd0, MODE_TICK, 1'b0, 16'd0, 1'b0, RES_IDLE},
    '{1'b0, REG_STEP_MS, 16'd0, MODE_REFRESH_END_AFTER, 1'b0, 16'd1, 1'b0, RES_IDLE},
    '{1'b0, REG_STEP_MS, 16'd0, MODE_TICK, 1'b0, 16'd0, 1'b0, RES_IDLE},
    '{1'b0, REG_STEP_MS, 16'd0, MODE_TICK, 1'b1, 16'd0, 1'b0, RES_IDLE}
  };

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic void lamp_enter(seq_ph_e ph, logic [15:0] len);
    lamp_ph      = ph;
    lamp_elapsed = '0;
    lamp_length  = len;
  endfunction

  function automatic result_t lamp_step(logic [2:0] mode, logic ok, logic [15:0] dl);
    result_t r;
    logic    tried;
    logic    hold;
    seq_ph_e ph;
    tried = 1'b0;
    hold  = 1'b0;
    case (mode)
      MODE_TICK: begin
        if (lamp_elapsed != TimeMax) lamp_elapsed++;
        if (lamp_dl_elapsed != TimeMax) lamp_dl_elapsed++;
        if (lamp_armed && lamp_dl_elapsed >= lamp_dl_length) begin
          lamp_want  = 1'b0;
          lamp_armed = 1'b0;
        end
        ph = lamp_ph;
        if (ph == S_IDLE) begin
          if (lamp_want) begin
            lamp_led = 1'b1;
            lamp_enter(S_REF_ON, lamp_cfg.refresh_pulse_ms);
          end
        end else if (lamp_elapsed >= lamp_length) begin
          case (ph)
            S_PRE_ON1, S_PRE_OFF1, S_PRE_ON2, S_POST_WAIT, S_POST_ON1, S_POST_OFF1,
            S_POST_ON2: begin
              lamp_led = (ph == S_PRE_OFF1 || ph == S_POST_WAIT || ph == S_POST_OFF1);
              lamp_enter(seq_ph_e'(ph + 5'd1), lamp_cfg.step_ms);
            end
            S_FAIL_ON1, S_FAIL_OFF1, S_FAIL_ON2, S_FAIL_OFF2, S_FAIL_ON3: begin
              lamp_led = (ph == S_FAIL_OFF1 || ph == S_FAIL_OFF2);
              lamp_enter(seq_ph_e'(ph + 5'd1), lamp_cfg.fail_flash_ms);
            end
            S_PRE_OFF2: begin
              lamp_fails = '0;
              lamp_enter(S_TRY, '0);
            end
            S_TRY: begin
              tried = 1'b1;
              if (ok) begin
                lamp_enter(S_POST_WAIT, lamp_cfg.post_wait_ms);
              end else begin
                if (lamp_fails != CountMax) lamp_fails++;
                if (lamp_fails >= lamp_cfg.max_attempts) begin
                  lamp_led = 1'b1;
                  lamp_enter(S_FAIL_ON1, lamp_cfg.fail_flash_ms);
                end else begin
                  lamp_enter(S_RETRY_WAIT, lamp_cfg.retry_delay_ms);
                end
              end
            end
            S_RETRY_WAIT: lamp_enter(S_TRY, '0);
            S_POST_OFF2, S_FAIL_OFF3: begin
              if (lamp_want) begin
                lamp_led = 1'b1;
                lamp_enter(S_REF_ON, lamp_cfg.refresh_pulse_ms);
              end else begin
                lamp_ph = S_IDLE;
                hold    = 1'b1;
              end
            end
            S_REF_ON, S_REF_OFF: begin
              if (!lamp_want) begin
                lamp_ph = S_IDLE;
                hold    = 1'b1;
              end else begin
                lamp_led = (ph == S_REF_OFF);
                lamp_enter(ph == S_REF_ON ? S_REF_OFF : S_REF_ON, lamp_cfg.refresh_pulse_ms);
              end
            end
            default: ;
          endcase
        end
      end
      MODE_START: begin
        lamp_led = 1'b1;
        lamp_enter(S_PRE_ON1, lamp_cfg.step_ms);
      end
      MODE_REFRESH_BEGIN: begin
        lamp_armed = 1'b0;
        lamp_want  = 1'b1;
        if (lamp_ph == S_IDLE) begin
          lamp_led = 1'b1;
          lamp_enter(S_REF_ON, lamp_cfg.refresh_pulse_ms);
        end
      end
      MODE_REFRESH_END: begin
        lamp_want  = 1'b0;
        lamp_armed = 1'b0;
      end
      MODE_REFRESH_END_AFTER: begin
        lamp_dl_elapsed = '0;
        lamp_dl_length  = dl;
        lamp_armed      = 1'b1;
      end
      default: ;
    endcase
    r.led_on          = lamp_led;
    r.phase           = lamp_ph;
    r.active          = (lamp_ph != S_IDLE);
    r.tx_busy         = r.active && lamp_ph != S_REF_ON && lamp_ph != S_REF_OFF;
    r.publish_attempt = tried;
    r.enter_hold      = hold;
    return r;
  endfunction

  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 11) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic logic [15:0] draw_ms();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return TimeMax;
    if (pick == 1) return 16'($urandom);
    if (pick < 6) return '0;
    return 16'($urandom_range(1, 4));
  endfunction

  function automatic logic [15:0] draw_tries();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return 16'(CountMax);
    if (pick == 1) return '0;
    if (pick == 2) return 16'($urandom_range(0, 255));
    return 16'($urandom_range(1, 4));
  endfunction

  task automatic send_request(input logic [2:0] mode, input logic ok, input logic [15:0] dl,
                              input logic known, input result_t want);
    int      gap;
    result_t predicted;
    gap = draw_wait(tx_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= mode;
    publish_ok_i  <= ok;
    deadline_ms_i <= dl;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = lamp_step(mode, ok, dl);
    lamp_due.push_back(known ? want : predicted);
  endtask

  // Write one register once all outstanding results are back; drop valid on the last one.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data, input logic last);
    in_valid_i <= 1'b0;
    while (lamp_due.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (last) cfg_valid_i <= 1'b0;
    case (idx)
      REG_STEP_MS:          lamp_cfg.step_ms = data;
      REG_FAIL_FLASH_MS:    lamp_cfg.fail_flash_ms = data;
      REG_POST_WAIT_MS:     lamp_cfg.post_wait_ms = data;
      REG_RETRY_DELAY_MS:   lamp_cfg.retry_delay_ms = data;
      REG_MAX_ATTEMPTS:     lamp_cfg.max_attempts = data[7:0];
      REG_REFRESH_PULSE_MS: lamp_cfg.refresh_pulse_ms = data;
      default: ;
    endcase
  endtask

  task automatic write_profile(input logic [15:0] step, input logic [15:0] flash,
                               input logic [15:0] post, input logic [15:0] retry,
                               input logic [15:0] tries, input logic [15:0] pulse);
    write_reg(REG_STEP_MS, step, 1'b0);
    write_reg(REG_FAIL_FLASH_MS, flash, 1'b0);
    write_reg(REG_POST_WAIT_MS, post, 1'b0);
    write_reg(REG_RETRY_DELAY_MS, retry, 1'b0);
    write_reg(REG_MAX_ATTEMPTS, tries, 1'b0);
    write_reg(REG_REFRESH_PULSE_MS, pulse, 1'b0);
    // unmapped index must leave everything as it is
    write_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 16'($urandom), 1'b1);
  endtask

  task automatic check_result();
    result_t got;
    result_t exp;
    got = '{led_on_o, phase_o, tx_busy_o, active_o, publish_attempt_o, enter_hold_o};
    results_seen++;
    if (lamp_due.size() == 0) begin
      faults++;
      if (faults <= REPORT_MAX)
        $display("result %0d arrived with nothing expected: %p", results_seen, got);
    end else begin
      exp = lamp_due.pop_front();
      if (got.led_on !== exp.led_on || got.phase !== exp.phase ||
          got.tx_busy !== exp.tx_busy || got.active !== exp.active ||
          got.publish_attempt !== exp.publish_attempt || got.enter_hold !== exp.enter_hold) begin
        faults++;
        if (faults <= REPORT_MAX)
          $display({"result %0d: expected led %b phase %0d busy %b active %b try %b hold %b,",
                    " got led %b phase %0d busy %b active %b try %b hold %b"},
                   results_seen, exp.led_on, exp.phase, exp.tx_busy, exp.active,
                   exp.publish_attempt, exp.enter_hold, got.led_on, got.phase, got.tx_busy,
                   got.active, got.publish_attempt, got.enter_hold);
      end
    end
  endtask

  initial begin : result_sink
    int pause;
    wait (rst_ni);
    forever begin
      pause = draw_wait(rx_calm);
      if (pause > 0) begin
        out_stall_i <= 1'b1;
        repeat (pause) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      check_result();
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_CYCLES) begin
      $display("[led_publish_sequencer_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int          k;
    int          round;
    int          pick;
    logic [2:0]  mode;
    logic        ok;
    logic [15:0] dl;
    wait (rst_ni);
    @(posedge clk_i);

    for (k = 0; k < PLAN_ROWS; k++) begin
      if (plan[k].cfg) begin
        write_reg(plan[k].idx, plan[k].data, !(k + 1 < PLAN_ROWS && plan[k + 1].cfg));
      end else begin
        send_request(plan[k].mode, plan[k].ok, plan[k].dl, plan[k].known, plan[k].want);
      end
    end

    for (round = 0; round < RANDOM_ROUNDS; round++) begin
      write_profile(draw_ms(), draw_ms(), draw_ms(), draw_ms(), draw_tries(), draw_ms());
      for (k = 0; k < ROUND_REQUESTS; k++) begin
        pick = $urandom_range(0, 99);
        ok   = ($urandom_range(0, 9) < 4);
        dl   = 16'($urandom);
        if (pick < 72) begin
          mode = MODE_TICK;
        end else if (pick < 80) begin
          mode = MODE_START;
        end else if (pick < 86) begin
          mode = MODE_REFRESH_BEGIN;
        end else if (pick < 91) begin
          mode = MODE_REFRESH_END;
        end else if (pick < 97) begin
          mode = MODE_REFRESH_END_AFTER;
          if ($urandom_range(0, 7) != 0) dl = 16'($urandom_range(0, 30));
        end else begin
          mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        end
        send_request(mode, ok, dl, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (lamp_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (faults == 0) begin
      $display("[led_publish_sequencer_core] OK");
    end else begin
      $display("[led_publish_sequencer_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/lps_pkg.sv
sv/lps_cfg.sv
sv/lps_step.sv
sv/led_publish_sequencer_core.sv
sim/tb.sv
